[src/mftt_pkg.sv]
// shared types and constants for the motor feedback turn tracker
`default_nettype none
package mftt_pkg;

	localparam int MOTOR_COUNT_DEF     = 4;
	localparam int COUNTS_PER_TURN_DEF = 8192;

	localparam int ID_W     = 11;
	localparam int THR_W    = 13;
	localparam int CFG_W    = 13;
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 96;

	localparam logic [ID_W-1:0]  BASE_ID_RST  = 11'd513;
	localparam logic [THR_W-1:0] WRAP_THR_RST = 13'd4000;

	typedef enum logic [0:0] {
		CFG_BASE_ID  = 1'b0,
		CFG_WRAP_THR = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]        temp;
		logic [15:0]       current;
		logic [15:0]       speed;
		logic [15:0]       angle;
		logic [ID_W-1:0]   frame_id;
	} frame_t;

	// input stage status handed to the tracker and the output side
	typedef struct packed {
		logic   valid;
		logic   match;
		frame_t frame;
	} s1_t;

	// packed so that motor_index lands in the lowest bits of tdata
	typedef struct packed {
		logic [7:0]         temperature;
		logic signed [15:0] current_value;
		logic signed [15:0] speed_value;
		logic signed [31:0] rotor_counts;
		logic [15:0]        angle_value;
		logic [1:0]         motor_index;
	} result_t;

endpackage
`default_nettype wire

[src/mftt_in_stage.sv]
// input register and motor identifier decode
`default_nettype none
module mftt_in_stage #(
	parameter int MOTOR_COUNT = mftt_pkg::MOTOR_COUNT_DEF,
	localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	input  wire logic                          s_axis_tready,
	input  wire logic [mftt_pkg::S_DATA_W-1:0] s_axis_tdata,
	input  wire logic                          advance,
	input  wire logic [mftt_pkg::ID_W-1:0]     base_id,
	output mftt_pkg::s1_t                      s1,
	output logic [MIDX_W-1:0]                  idx
);
	import mftt_pkg::*;

	logic              valid_s1;
	frame_t            frame_s1;
	frame_t            frame_in;
	logic [ID_W:0]     diff;

	assign frame_in.frame_id = s_axis_tdata[10:0];
	assign frame_in.angle    = {s_axis_tdata[18:11], s_axis_tdata[26:19]};
	assign frame_in.speed    = {s_axis_tdata[34:27], s_axis_tdata[42:35]};
	assign frame_in.current  = {s_axis_tdata[50:43], s_axis_tdata[58:51]};
	assign frame_in.temp     = s_axis_tdata[66:59];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			frame_s1 <= frame_in;
		end
	end

	// borrow bit set means the identifier lies below the window
	assign diff = {1'b0, frame_s1.frame_id} - {1'b0, base_id};

	assign s1.valid = valid_s1;
	assign s1.match = !diff[ID_W] && (diff[ID_W-1:0] < ID_W'(MOTOR_COUNT));
	assign s1.frame = frame_s1;
	assign idx      = diff[MIDX_W-1:0];

endmodule
`default_nettype wire

[src/mftt_track.sv]
// per-motor angle history, turn count and zero offset with result assembly
`default_nettype none
module mftt_track #(
	parameter int MOTOR_COUNT     = mftt_pkg::MOTOR_COUNT_DEF,
	parameter int COUNTS_PER_TURN = mftt_pkg::COUNTS_PER_TURN_DEF,
	localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       fire,
	input  wire logic [MIDX_W-1:0]          idx,
	input  wire mftt_pkg::frame_t           frame,
	input  wire logic [mftt_pkg::THR_W-1:0] wrap_threshold,
	output mftt_pkg::result_t               res,
	output logic [MOTOR_COUNT-1:0]          rezero_pend
);
	import mftt_pkg::*;

	localparam logic [31:0] CPT = 32'(COUNTS_PER_TURN);

	logic [15:0]        last_angle_q  [MOTOR_COUNT];
	logic [31:0]        turn_count_q  [MOTOR_COUNT];
	logic [15:0]        zero_offset_q [MOTOR_COUNT];
	logic [MOTOR_COUNT-1:0] needs_rezero_q;

	logic               rezero;
	logic [15:0]        offset_new;
	logic signed [17:0] delta;
	logic signed [17:0] thr_s;
	logic               wrap_dn;
	logic               wrap_up;
	logic [31:0]        turn_new;
	logic [31:0]        prod;
	logic [MIDX_W+1:0]  idx_ext;

	assign rezero     = needs_rezero_q[idx];
	assign offset_new = rezero ? frame.angle : zero_offset_q[idx];

	assign delta = $signed({{2{frame.angle[15]}}, frame.angle})
		- $signed({{2{last_angle_q[idx][15]}}, last_angle_q[idx]});
	assign thr_s   = $signed({5'b0, wrap_threshold});
	assign wrap_dn = delta < -thr_s;
	assign wrap_up = delta > thr_s;

	always_comb begin
		turn_new = turn_count_q[idx];
		if (rezero) begin
			turn_new = '0;
		end else if (wrap_dn) begin
			turn_new = turn_count_q[idx] + 32'd1;
		end else if (wrap_up) begin
			turn_new = turn_count_q[idx] - 32'd1;
		end
	end

	assign prod = turn_new * CPT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needs_rezero_q <= '1;
		end else if (fire) begin
			needs_rezero_q[idx] <= 1'b0;
		end
	end

	// history only read once the motor's first frame has written it
	always_ff @(posedge clk) begin
		if (fire) begin
			last_angle_q[idx]  <= frame.angle;
			turn_count_q[idx]  <= turn_new;
			zero_offset_q[idx] <= offset_new;
		end
	end

	assign idx_ext = (MIDX_W+2)'(idx);

	assign res.motor_index   = idx_ext[1:0];
	assign res.angle_value   = frame.angle;
	assign res.rotor_counts  = $signed(prod + {{16{frame.angle[15]}}, frame.angle}
		- {{16{offset_new[15]}}, offset_new});
	assign res.speed_value   = $signed(frame.speed);
	assign res.current_value = $signed(frame.current);
	assign res.temperature   = frame.temp;

	assign rezero_pend = needs_rezero_q;

endmodule
`default_nettype wire

[src/motor_feedback_turn_tracker.sv]
// Motor feedback turn tracker, top level.
// Input stream: one beat per received feedback frame (identifier plus seven
// payload bytes). Frames whose identifier is base_id .. base_id+MOTOR_COUNT-1
// belong to a motor; all other beats are consumed and produce nothing.
// Output stream: one beat per matching frame with the motor index, the
// unpacked angle, speed, current and temperature, and the multi-turn count.
// Path: an accepted matching frame passes the input register, then the result
// register, before it appears on the output.
// Throughput: one frame per cycle while the output beat is taken; the
// per-motor state is read, updated and written back between the registers.
// Config port: base_id (index 0) and wrap_threshold (index 1); the user must
// write them only while no frame is in flight; the block does not enforce it.
// Reset: config returns to 513 and 4000; every motor waits for a first frame
// that captures its zero offset and clears its turn count.
// Stall: while the output beat is not taken, the result register holds, a
// matching frame behind it waits in the input register, and s_axis_tready drops.
`default_nettype none
module motor_feedback_turn_tracker #(
	parameter int MOTOR_COUNT     = mftt_pkg::MOTOR_COUNT_DEF,
	parameter int COUNTS_PER_TURN = mftt_pkg::COUNTS_PER_TURN_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// frame_id[10:0], angle_high, angle_low, speed_high, speed_low,
	// current_high, current_low, temp_byte, zero fill
	input  wire logic [mftt_pkg::S_DATA_W-1:0] s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// motor_index[1:0], angle_value[15:0], rotor_counts[31:0],
	// speed_value[15:0], current_value[15:0], temperature[7:0], zero fill
	output logic [mftt_pkg::M_DATA_W-1:0]      m_axis_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [0:0]                    cfg_index,
	input  wire logic [mftt_pkg::CFG_W-1:0]    cfg_wdata
);
	import mftt_pkg::*;

	localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	logic [ID_W-1:0]        base_id_q;
	logic [THR_W-1:0]       wrap_thr_q;
	s1_t                    s1;
	logic [MIDX_W-1:0]      idx;
	logic                   out_free;
	logic                   advance;
	logic                   fire;
	result_t                res;
	result_t                res_q;
	logic                   m_valid_q;
	logic [MOTOR_COUNT-1:0] rezero_pend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_id_q  <= BASE_ID_RST;
			wrap_thr_q <= WRAP_THR_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BASE_ID:  base_id_q  <= cfg_wdata[ID_W-1:0];
				CFG_WRAP_THR: wrap_thr_q <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// non-matching beats leave the input register without a result slot
	assign out_free      = !m_valid_q || m_axis_tready;
	assign advance       = s1.valid && (!s1.match || out_free);
	assign fire          = s1.valid && s1.match && out_free;
	assign s_axis_tready = !s1.valid || advance;

	mftt_in_stage #(
		.MOTOR_COUNT(MOTOR_COUNT)
	) u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.advance       (advance),
		.base_id       (base_id_q),
		.s1            (s1),
		.idx           (idx)
	);

	mftt_track #(
		.MOTOR_COUNT     (MOTOR_COUNT),
		.COUNTS_PER_TURN (COUNTS_PER_TURN)
	) u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.idx            (idx),
		.frame          (s1.frame),
		.wrap_threshold (wrap_thr_q),
		.res            (res),
		.rezero_pend    (rezero_pend)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {(M_DATA_W - $bits(result_t))'(0), res_q};

`ifndef SYNTHESIS
	a_fire_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_axis_tvalid && (res_q == $past(res)))
		else $error("result beat did not land in the output register");

	a_no_fire_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_axis_tready) |-> !fire)
		else $error("state updated while the output beat was stalled");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1.valid && !advance) |=> s1.valid && $stable(s1.frame))
		else $error("waiting frame lost from the input register");

	a_rezero_only_clears: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(rezero_pend) <= $past($countones(rezero_pend)))
		else $error("re-zero flag set again after reset");
`endif

endmodule
`default_nettype wire
